@@ hw/rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared sizes, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int SLOTS      = 64;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int LANES      = 8;
	localparam int LANE_W     = $clog2(LANES);
	localparam int GRPS       = SLOTS / LANES;
	localparam int GRP_W      = $clog2(GRPS);
	localparam int BB_W       = 16;
	localparam int OFS_W      = 22;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'b1;

	// outcome of checking one group of slots
	typedef struct packed {
		logic              hit;   // a free slot was found in the group
		logic [LANE_W-1:0] lane;  // lowest free lane
		logic              last;  // no later group lies below the limit
	} fbpa_scan_t;

endpackage

@@ hw/rtl/fbpa_scan.sv @@
// ----------------------------------------------------------------------------
// fbpa_scan
// Group checker: finds the lowest free slot of one group at or above the hint
// and below the slot limit.
// ----------------------------------------------------------------------------
module fbpa_scan (
	input  logic [fbpa_pkg::SLOTS-1:0] used,
	input  logic [fbpa_pkg::GRP_W-1:0] grp,
	input  logic [fbpa_pkg::CNT_W-1:0] hint,
	input  logic [fbpa_pkg::CNT_W-1:0] limit,
	output fbpa_pkg::fbpa_scan_t       res
);
	import fbpa_pkg::*;

	logic [LANES-1:0]  cand;
	logic [LANE_W-1:0] lane;
	logic [CNT_W-1:0]  next_start;

	always_comb begin
		logic [SLOT_W-1:0] idx;
		for (int j = 0; j < LANES; j++) begin
			idx     = {grp, LANE_W'(j)};
			cand[j] = !used[idx] && ({1'b0, idx} >= hint) && ({1'b0, idx} < limit);
		end
	end

	// lowest candidate wins
	always_comb begin
		lane = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			if (cand[j]) begin
				lane = LANE_W'(j);
			end
		end
	end

	assign next_start = CNT_W'({grp, {LANE_W{1'b0}}}) + CNT_W'(LANES);

	assign res.hit  = |cand;
	assign res.lane = lane;
	assign res.last = (next_start >= limit);

endmodule

@@ hw/rtl/fbpa_mul.sv @@
// ----------------------------------------------------------------------------
// fbpa_mul
// Registered offset multiplier: slot index times block size.
// ----------------------------------------------------------------------------
module fbpa_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [fbpa_pkg::SLOT_W-1:0] slot,
	input  logic [fbpa_pkg::BB_W-1:0]   block_bytes,
	output logic [fbpa_pkg::OFS_W-1:0]  product
);
	import fbpa_pkg::*;

	logic [SLOT_W+BB_W-1:0] full;
	logic [OFS_W-1:0]       product_q;

	assign full = {{BB_W{1'b0}}, slot} * {{SLOT_W{1'b0}}, block_bytes};

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= full[OFS_W-1:0];
		end
	end

	assign product = product_q;

endmodule

@@ hw/rtl/fixed_block_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block pool allocator: one used flag per slot, a next-free hint
// and a used count. Allocate scans up from the hint, free releases a slot.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | opcode, free_slot
//  out      | out_valid / out_stall | granted_slot, byte_offset, status, used_count
//  cfg      | cfg_wr_en             | cfg_index, cfg_data
//
//  One transaction at a time. An allocate steps through the group
//  checker (eight slots per cycle, from the hint's group up to the limit).
//  A granted slot then passes through the offset multiplier; every
//  transaction then loads its result into the output register before the
//  sequencer returns to idle. A free updates the pool and loads its result.
//  in_stall is high whenever the sequencer is not idle.
//  Reset clears every used flag, the hint and the count at once.
//  A stalled result waits in the output register; the sequencer holds its
//  next result until that register empties.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// request
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [fbpa_pkg::SLOT_W-1:0]     free_slot,
	// result
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fbpa_pkg::SLOT_W-1:0]     granted_slot,
	output logic [fbpa_pkg::OFS_W-1:0]      byte_offset,
	output logic [fbpa_pkg::ST_W-1:0]       status,
	output logic [fbpa_pkg::CNT_W-1:0]      used_count,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fbpa_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FREE = 3'd2;
	localparam logic [2:0] S_MULT = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]        state_q;

	// pool state
	logic [SLOTS-1:0]  used_q;         // 1 = slot in use
	logic [CNT_W-1:0]  hint_q;         // every slot below it is in use
	logic [CNT_W-1:0]  count_q;

	// configuration
	logic [BB_W-1:0]   block_bytes_q;
	logic [CNT_W-1:0]  active_slots_q;

	// current transaction
	logic              op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [GRP_W-1:0]  grp_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [ST_W-1:0]   res_status_q;

	// output register
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [OFS_W-1:0]  out_ofs_q;
	logic [ST_W-1:0]   out_status_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [CNT_W-1:0]  limit;
	fbpa_scan_t        scan;
	logic [SLOT_W-1:0] hit_slot;
	logic [OFS_W-1:0]  product;
	logic              free_bad;
	logic              out_free;

	// active_slots clamped to the pool size
	assign limit = (active_slots_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : active_slots_q;

	fbpa_scan u_scan (
		.used  (used_q),
		.grp   (grp_q),
		.hint  (hint_q),
		.limit (limit),
		.res   (scan)
	);

	assign hit_slot = {grp_q, scan.lane};

	fbpa_mul u_mul (
		.clk         (clk),
		.en          (state_q == S_MULT),
		.slot        (res_slot_q),
		.block_bytes (block_bytes_q),
		.product     (product)
	);

	// out of range or already free
	assign free_bad = ({1'b0, slot_q} >= limit) || !used_q[slot_q];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q  <= BB_W'(64);
			active_slots_q <= CNT_W'(64);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BLOCK_BYTES:  block_bytes_q  <= cfg_data[BB_W-1:0];
				CFG_ACTIVE_SLOTS: active_slots_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	// sequencer and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			hint_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (opcode == OP_ALLOC) ? S_SCAN : S_FREE;
					end
				end
				S_SCAN: begin
					if (scan.hit) begin
						used_q[hit_slot] <= 1'b1;
						count_q          <= count_q + 1'b1;
						hint_q           <= {1'b0, hit_slot} + 1'b1;
						state_q          <= S_MULT;
					end else if (scan.last) begin
						state_q <= S_RESP;
					end
				end
				S_FREE: begin
					if (!free_bad) begin
						used_q[slot_q] <= 1'b0;
						if (count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
						if (hint_q > {1'b0, slot_q}) begin
							hint_q <= {1'b0, slot_q};
						end
					end
					state_q <= S_RESP;
				end
				S_MULT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= opcode;
				slot_q <= free_slot;
				grp_q <= hint_q[SLOT_W-1:LANE_W];
			end
			S_SCAN: begin
				if (scan.hit) begin
					res_slot_q   <= hit_slot;
					res_status_q <= ST_OK;
				end else if (scan.last) begin
					res_slot_q   <= '0;
					res_status_q <= ST_FULL;
				end else begin
					grp_q <= grp_q + 1'b1;
				end
			end
			S_FREE: begin
				res_slot_q   <= '0;
				res_status_q <= free_bad ? ST_BAD_FREE : ST_OK;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_slot_q   <= res_slot_q;
			out_ofs_q    <= (op_q == OP_ALLOC && res_status_q == ST_OK) ? product : '0;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = out_slot_q;
	assign byte_offset  = out_ofs_q;
	assign status       = out_status_q;
	assign used_count   = out_count_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------

	// the count always matches the used flags
	a_count_tracks_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(used_q))
		else $error("used count out of step with slot flags");

	// an accepted transaction starts a scan or a free
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_SCAN || state_q == S_FREE)
		else $error("accepted transaction did not start");

	// results are loaded only from the response state
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result appeared outside the response state");

	// failed transactions carry no slot and no offset
	a_fail_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_slot_q == '0 && out_ofs_q == '0)
		else $error("failed transaction carries a slot or offset");

endmodule

@@ tb/fixed_block_pool_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit_test
// Self-checking bench for the block pool allocator. A directed opening covers
// empty and full pools, double and out-of-range frees, a zero-slot pool and
// clamped slot counts; random phases then fill and drain the pool under
// changing block sizes and slot counts, with random gaps on both channels.
// Every result transaction is checked against an in-bench model of the pool.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit_test;

	import fbpa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
	} pool_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [OFS_W-1:0]  ofs;
		logic [ST_W-1:0]   st;
		logic [CNT_W-1:0]  used;
	} pool_reply_t;

	// DUT connections; every input starts at a known value
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  opcode     = OP_ALLOC;
	logic [SLOT_W-1:0]     free_slot  = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [SLOT_W-1:0]     granted_slot;
	logic [OFS_W-1:0]      byte_offset;
	logic [ST_W-1:0]       status;
	logic [CNT_W-1:0]      used_count;
	logic                  cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_BLOCK_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// pool model: free flags, hint, used count and the two registers
	logic [SLOTS-1:0] model_open;
	int               pool_hint;
	int               pool_used;
	int               pool_bb;
	int               pool_active;

	pool_req_t   request_backlog[$];
	pool_reply_t pending_replies[$];
	pool_req_t   next_req;
	pool_reply_t want_reply;

	bit quiet = 1'b0;   // no new gaps on either side while set
	int idle_left  = 0;
	int stall_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	fixed_block_pool_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.free_slot    (free_slot),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_slot (granted_slot),
		.byte_offset  (byte_offset),
		.status       (status),
		.used_count   (used_count),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// slot count clamped to the pool size
	function automatic int pool_limit();
		return (pool_active > SLOTS) ? SLOTS : pool_active;
	endfunction

	// applies one request to the pool model and returns the reply it earns
	function automatic pool_reply_t pool_reply_for(input logic op,
			input logic [SLOT_W-1:0] slot);
		pool_reply_t r;
		int lim;
		int k;
		lim = pool_limit();
		r = '0;
		r.st = ST_OK;
		if (op == OP_ALLOC) begin
			k = pool_hint;
			while (k < lim && !model_open[k])
				k++;
			if (k < lim) begin
				model_open[k] = 1'b0;
				pool_used++;
				pool_hint = k + 1;
				r.slot = SLOT_W'(k);
				r.ofs = OFS_W'(k * pool_bb);
			end else begin
				r.st = ST_FULL;
			end
		end else begin
			if (int'(slot) >= lim || model_open[slot]) begin
				r.st = ST_BAD_FREE;
			end else begin
				model_open[slot] = 1'b1;
				if (pool_used > 0)
					pool_used--;
				if (pool_hint > int'(slot))
					pool_hint = int'(slot);
			end
		end
		r.used = CNT_W'(pool_used);
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic push_req(input logic op, input int slot);
		pool_req_t q;
		q.op = op;
		q.slot = SLOT_W'(slot);
		request_backlog.push_back(q);
	endtask

	// wait until every request is accepted and every reply has come back
	task automatic settle();
		while (request_backlog.size() != 0 || in_valid || pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_BLOCK_BYTES)
			pool_bb = val & 16'hFFFF;
		else
			pool_active = val & 7'h7F;
	endtask

	// One random phase: both registers set, then bursts that swing between
	// filling the pool and draining it. Frees mostly target used slots.
	task automatic run_phase(input int bb, input int act, input int n_items);
		logic [SLOT_W-1:0] used_list[$];
		int  left;
		int  len;
		int  k;
		int  lim;
		bit  filling;
		cfg_write(CFG_BLOCK_BYTES, bb);
		cfg_write(CFG_ACTIVE_SLOTS, act);
		left = n_items;
		filling = 1'b1;
		while (left > 0) begin
			lim = pool_limit();
			used_list.delete();
			for (k = 0; k < lim; k++)
				if (!model_open[k])
					used_list.push_back(SLOT_W'(k));
			if (used_list.size() == lim)
				filling = 1'b0;
			else if (used_list.size() == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 7) == 0)
				filling = !filling;
			quiet = ($urandom_range(0, 3) == 0);
			len = $urandom_range(1, 12);
			if (len > left)
				len = left;
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 99) < (filling ? 90 : 20))
					push_req(OP_ALLOC, $urandom_range(0, SLOTS - 1));
				else if (used_list.size() != 0 && $urandom_range(0, 4) != 0)
					push_req(OP_FREE, used_list[$urandom_range(0, used_list.size() - 1)]);
				else
					push_req(OP_FREE, $urandom_range(0, SLOTS - 1));
			end
			left -= len;
			settle();
		end
	endtask

	// request driver: takes the next request from the backlog, predicts the
	// reply at the accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				pending_replies.push_back(pool_reply_for(opcode, free_slot));
			if (!in_valid || !in_stall) begin
				if (idle_left != 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					next_req = request_backlog.pop_front();
					in_valid  <= 1'b1;
					opcode    <= next_req.op;
					free_slot <= next_req.slot;
					idle_left = pick_gap(quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor: checks each accepted reply, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					$display("%0t ns: stray reply, expected none, actual slot %0d status %0d",
						$time, granted_slot, status);
					mismatches++;
				end else begin
					want_reply = pending_replies.pop_front();
					check_field("granted_slot", want_reply.slot, granted_slot);
					check_field("byte_offset", want_reply.ofs, byte_offset);
					check_field("status", want_reply.st, status);
					check_field("used_count", want_reply.used, used_count);
				end
			end
			if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
				stall_left = pick_gap(1'b0);
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		model_open  = '1;
		pool_hint   = 0;
		pool_used   = 0;
		pool_bb     = 64;
		pool_active = 64;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: frees of free slots, hint lowering, reuse
		push_req(OP_FREE, 0);
		push_req(OP_ALLOC, 0);
		push_req(OP_ALLOC, 63);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 1);
		push_req(OP_FREE, 1);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 63);
		push_req(OP_FREE, 0);
		settle();

		// four slots, widest block: scan past used slots, full pool,
		// free out of range
		cfg_write(CFG_ACTIVE_SLOTS, 4);
		cfg_write(CFG_BLOCK_BYTES, 65535);
		push_req(OP_ALLOC, 0);
		push_req(OP_ALLOC, 0);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 63);
		push_req(OP_FREE, 2);
		push_req(OP_ALLOC, 0);
		settle();

		// pool with no slots
		cfg_write(CFG_ACTIVE_SLOTS, 0);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 0);
		settle();

		// slot count above the pool size, zero block size
		cfg_write(CFG_ACTIVE_SLOTS, 127);
		cfg_write(CFG_BLOCK_BYTES, 0);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 3);
		settle();

		run_phase(1, 64, 120);
		run_phase(65535, 64, 140);
		run_phase(64, 100, 110);
		run_phase(1000, 1, 40);
		run_phase($urandom_range(1, 65535), $urandom_range(1, 64), 110);
		run_phase($urandom_range(1, 65535), 2, 40);
		run_phase(7, 32, 110);
		run_phase(65535, 64, 140);
		run_phase($urandom_range(1, 65535), 127, 110);
		run_phase($urandom_range(1, 65535), $urandom_range(1, 64), 110);

		quiet = 1'b0;
		settle();
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_scan.sv
hw/rtl/fbpa_mul.sv
hw/rtl/fixed_block_pool_allocator_unit.sv
tb/fixed_block_pool_allocator_unit_test.sv
